[rtl/mah_pkg.sv]
// Shared constants, operation codes and control types for the magnetometer averager.
`timescale 1ns / 1ps
package mah_pkg;

	localparam int WORD_W     = 16;
	localparam int OP_W       = 3;
	localparam int STAT_W     = 8;
	localparam int WINDOW_DEF = 10;

	typedef logic signed [WORD_W-1:0] word_t;

	// Operation codes carried by each input word
	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE    = 3'd0,
		OP_CAL_START = 3'd1,
		OP_CAL_END   = 3'd2,
		OP_LOAD_MIN  = 3'd3,
		OP_LOAD_MAX  = 3'd4
	} op_t;

	// Bound update controls handed to each axis at the bound stage
	typedef struct packed {
		logic sample;
		logic clear;
		logic load_min;
		logic load_max;
		logic cal;
	} bnd_ctl_t;

endpackage

[rtl/mah_samp_if.sv]
// Input channel: operation, status byte and three sensor words.
`timescale 1ns / 1ps
interface mah_samp_if import mah_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [STAT_W-1:0]   status_byte;
	logic signed [WORD_W-1:0] word_y;
	logic signed [WORD_W-1:0] word_x;
	logic signed [WORD_W-1:0] word_z;

	modport source (output valid, op, status_byte, word_y, word_x, word_z, input ready);
	modport sink   (input valid, op, status_byte, word_y, word_x, word_z, output ready);
endinterface

[rtl/mah_res_if.sv]
// Result channel: centered field, raw means and retrigger flag.
`timescale 1ns / 1ps
interface mah_res_if import mah_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] field_x;
	logic signed [WORD_W-1:0] field_y;
	logic signed [WORD_W-1:0] field_z;
	logic signed [WORD_W-1:0] mean_x;
	logic signed [WORD_W-1:0] mean_y;
	logic signed [WORD_W-1:0] mean_z;
	logic                     retrigger;

	modport source (output valid, field_x, field_y, field_z, mean_x, mean_y, mean_z,
		retrigger, input ready);
	modport sink   (input valid, field_x, field_y, field_z, mean_x, mean_y, mean_z,
		retrigger, output ready);
endinterface

[rtl/mah_cell.sv]
// One history tap: holds a sample and passes it to the next tap on a shift.
`timescale 1ns / 1ps
module mah_cell import mah_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  word_t d,
	output word_t q
);

	word_t val_q;

	// Take the neighbor's sample on each accepted sample word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

[rtl/mah_axis.sv]
// One axis: tap chain with running sum, reciprocal divide, bound tracking, centering.
`timescale 1ns / 1ps
module mah_axis import mah_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter bit NEGATE = 1'b0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     push,
	input  word_t    word_in,
	input  bnd_ctl_t bnd,
	output word_t    res,
	output word_t    mean
);

	localparam int LW  = $clog2(WINDOW);
	localparam int SW  = WORD_W + LW;
	localparam int K   = SW + LW;
	localparam int PW  = 2 * SW + 1;
	localparam int QW  = WORD_W + 1;
	localparam longint unsigned MUL_L = ((64'd1 << K) + longint'(WINDOW) - 1) / longint'(WINDOW);
	localparam logic [SW:0] MUL = MUL_L[SW:0];

	word_t tap [WINDOW];

	logic signed [SW-1:0] sum_q;
	logic signed [SW-1:0] sum_next;
	logic signed [SW-1:0] sum_s1;
	word_t                word_s1;
	logic [SW-1:0]        mag_s1;
	logic [PW-1:0]        prod_s2;
	logic                 neg_s2;
	word_t                word_s2;
	logic [QW-1:0]        quo_s2;
	word_t                mean_c;
	word_t                mean_s3;
	word_t                word_s3;
	word_t                min_q;
	word_t                max_q;
	word_t                lo_nx;
	word_t                hi_nx;
	word_t                mean_s4;
	word_t                lo_s4;
	word_t                hi_s4;
	logic signed [WORD_W:0] bsum;
	logic signed [WORD_W:0] bsum_r;
	word_t                center_s5;
	word_t                mean_s5;
	word_t                diff;
	word_t                res_q;
	word_t                mean_q;

	// Build the tap chain, newest sample at tap 0
	for (genvar i = 0; i < WINDOW; i++) begin : g_tap
		if (i == 0) begin : g_head
			mah_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (push),
				.d      (word_in),
				.q      (tap[i])
			);
		end else begin : g_body
			mah_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (push),
				.d      (tap[i-1]),
				.q      (tap[i])
			);
		end
	end

	// Add the new sample, drop the one falling off the end of the chain
	assign sum_next = sum_q + SW'(word_in) - SW'(tap[WINDOW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (push) begin
			sum_q <= sum_next;
		end
	end

	// Magnitude of the sum for the reciprocal multiply
	assign mag_s1 = sum_s1[SW-1] ? SW'(-sum_s1) : SW'(sum_s1);

	// Quotient toward zero, sign restored
	assign quo_s2 = prod_s2[K +: QW];
	assign mean_c = neg_s2 ? WORD_W'(-quo_s2) : WORD_W'(quo_s2);

	// Bound update: clear, load, or widen by the mean while calibrating
	always_comb begin
		lo_nx = min_q;
		hi_nx = max_q;
		if (bnd.clear) begin
			lo_nx = '0;
			hi_nx = '0;
		end else if (bnd.load_min) begin
			lo_nx = word_s3;
		end else if (bnd.load_max) begin
			hi_nx = word_s3;
		end else if (bnd.sample && bnd.cal) begin
			if (mean_s3 < min_q) begin
				lo_nx = mean_s3;
			end
			if (mean_s3 > max_q) begin
				hi_nx = mean_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
		end else if (en) begin
			min_q <= lo_nx;
			max_q <= hi_nx;
		end
	end

	// Center is half the bound sum, truncated toward zero
	assign bsum   = (WORD_W+1)'(lo_s4) + (WORD_W+1)'(hi_s4);
	assign bsum_r = bsum + signed'({{WORD_W{1'b0}}, bsum[WORD_W]});

	// Remove the center, flip the axis if required
	assign diff = mean_s5 - center_s5;

	// Advance the datapath stages together
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1    <= push ? sum_next : sum_q;
			word_s1   <= word_in;
			prod_s2   <= PW'(mag_s1) * PW'(MUL);
			neg_s2    <= sum_s1[SW-1];
			word_s2   <= word_s1;
			mean_s3   <= mean_c;
			word_s3   <= word_s2;
			mean_s4   <= mean_s3;
			lo_s4     <= lo_nx;
			hi_s4     <= hi_nx;
			center_s5 <= bsum_r[WORD_W:1];
			mean_s5   <= mean_s4;
			res_q     <= NEGATE ? -diff : diff;
			mean_q    <= mean_s5;
		end
	end

	assign res  = res_q;
	assign mean = mean_q;

endmodule

[rtl/magnetometer_average_hard_iron_unit.sv]
// Magnetometer moving average with hard-iron calibration, top level.
// Takes one word per cycle and presents the result of a sample word on the
// output after six register stages; control words travel the same six
// register stages and give no result. Each axis keeps a chain of
// WINDOW cells and a running sum, so the window length does not change the
// rate; the mean comes from a reciprocal multiply and the bounds are tracked
// in the stage after it. All stages stall together while a finished result
// waits on the output register; the input is ready whenever that register is
// empty or being taken. No clearing pass runs after reset.
`timescale 1ns / 1ps
module magnetometer_average_hard_iron_unit import mah_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mah_samp_if.sink     samp,
	mah_res_if.source    res
);

	typedef struct packed {
		logic valid;
		op_t  op;
		logic retrig;
	} stg_t;

	stg_t     stg_s1, stg_s2, stg_s3, stg_s4, stg_s5;
	logic     en;
	logic     acc;
	logic     push;
	logic     cal_q;
	logic     out_v_q;
	logic     retrig_q;
	bnd_ctl_t bnd;
	word_t    res_x, res_y, res_z;
	word_t    mean_x, mean_y, mean_z;

	// Advance whenever the output register is free or being drained
	assign en   = !out_v_q || res.ready;
	assign acc  = samp.valid && en;
	assign push = acc && (op_t'(samp.op) == OP_SAMPLE);

	assign samp.ready = en;

	// Carry word control down the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s1 <= '0;
			stg_s2 <= '0;
			stg_s3 <= '0;
			stg_s4 <= '0;
			stg_s5 <= '0;
		end else if (en) begin
			stg_s1 <= '{valid: acc, op: op_t'(samp.op), retrig: (samp.status_byte != '0)};
			stg_s2 <= stg_s1;
			stg_s3 <= stg_s2;
			stg_s4 <= stg_s3;
			stg_s5 <= stg_s4;
		end
	end

	// Decode bound controls at the bound stage
	always_comb begin
		bnd = '0;
		bnd.cal = cal_q;
		if (stg_s3.valid) begin
			case (stg_s3.op)
				OP_SAMPLE:    bnd.sample   = 1'b1;
				OP_CAL_START: bnd.clear    = 1'b1;
				OP_LOAD_MIN:  bnd.load_min = 1'b1;
				OP_LOAD_MAX:  bnd.load_max = 1'b1;
				default:      bnd.sample   = 1'b0;
			endcase
		end
	end

	// Hold the calibration mode, switched at the bound stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= 1'b0;
		end else if (en && stg_s3.valid) begin
			case (stg_s3.op)
				OP_CAL_START: cal_q <= 1'b1;
				OP_CAL_END:   cal_q <= 1'b0;
				default:      cal_q <= cal_q;
			endcase
		end
	end

	// Output valid only for sample words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= stg_s5.valid && (stg_s5.op == OP_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			retrig_q <= stg_s5.retrig;
		end
	end

	mah_axis #(.WINDOW(WINDOW), .NEGATE(1'b0)) u_axis_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.push    (push),
		.word_in (samp.word_x),
		.bnd     (bnd),
		.res     (res_x),
		.mean    (mean_x)
	);

	mah_axis #(.WINDOW(WINDOW), .NEGATE(1'b0)) u_axis_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.push    (push),
		.word_in (samp.word_y),
		.bnd     (bnd),
		.res     (res_y),
		.mean    (mean_y)
	);

	mah_axis #(.WINDOW(WINDOW), .NEGATE(1'b1)) u_axis_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.push    (push),
		.word_in (samp.word_z),
		.bnd     (bnd),
		.res     (res_z),
		.mean    (mean_z)
	);

	assign res.valid     = out_v_q;
	assign res.field_x   = res_x;
	assign res.field_y   = res_y;
	assign res.field_z   = res_z;
	assign res.mean_x    = mean_x;
	assign res.mean_y    = mean_y;
	assign res.mean_z    = mean_z;
	assign res.retrigger = retrig_q;

endmodule

[rtl/mah_checker.sv]
// Port-level checks on the averager, bound to the top level.
`timescale 1ns / 1ps
module mah_checker import mah_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OP_W-1:0]   in_op,
	input logic              out_valid,
	input logic              out_ready,
	input word_t             field_x,
	input word_t             field_y,
	input word_t             field_z,
	input word_t             mean_x,
	input word_t             mean_y,
	input word_t             mean_z,
	input logic              retrigger
);

	// Nothing is offered in the cycle after a reset cycle
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result offered during reset");

	// Input is taken whenever the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready || !out_valid) |-> in_ready)
		else $error("input stalled with free output");

	// A stalled result holds its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(field_x) && $stable(field_y)
			&& $stable(field_z) && $stable(mean_x) && $stable(mean_y)
			&& $stable(mean_z) && $stable(retrigger)))
		else $error("stalled result changed");

	// A sample word taken with no back-pressure shows a valid result on the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_op == OP_SAMPLE) && out_ready)
			##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
			|=> out_valid)
		else $error("sample result missing");

endmodule

bind magnetometer_average_hard_iron_unit mah_checker u_mah_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samp.valid),
	.in_ready  (samp.ready),
	.in_op     (samp.op),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.field_x   (res.field_x),
	.field_y   (res.field_y),
	.field_z   (res.field_z),
	.mean_x    (res.mean_x),
	.mean_y    (res.mean_y),
	.mean_z    (res.mean_z),
	.retrigger (res.retrigger)
);
